/* hdl/vlrr_pkg.sv */
// ----------------------------------------------------------------------------
// vlrr_pkg
// Shared types and constants for the velocity layer round-robin selector.
// ----------------------------------------------------------------------------
package vlrr_pkg;

    // table geometry
    localparam int NUM_NOTES    = 128;
    localparam int MAX_SLOTS    = 16;
    localparam int MAX_VARIANTS = 16;
    localparam int NOTE_W       = 7;
    localparam int SLOT_W       = 4;
    localparam int VAR_W        = 4;
    localparam int CNT_W        = 5;
    localparam int VEL_W        = 7;
    localparam int GAIN_W       = 14;
    localparam int TABLE_DEPTH  = NUM_NOTES * MAX_SLOTS;
    localparam int TABLE_AW     = NOTE_W + SLOT_W;

    // random generator
    localparam int          RNG_W      = 32;
    localparam logic [31:0] LCG_MUL    = 32'd1664525;
    localparam logic [31:0] LCG_ADD    = 32'd1013904223;
    localparam logic [31:0] SEED_RESET = 32'd1;

    // remainder unit: four quotient bits per cycle
    localparam int MOD_BITS_PER_STEP = 4;
    localparam int MOD_STEPS         = RNG_W / MOD_BITS_PER_STEP;
    localparam int MOD_STEP_W        = $clog2(MOD_STEPS);

    // remembered variant when nothing has been played yet
    localparam logic [CNT_W-1:0] LAST_NONE = 5'd31;

    localparam logic [CNT_W-1:0] SLOT_CNT_MAX = 5'd16;
    localparam logic [CNT_W-1:0] VAR_CNT_MAX  = 5'd16;

    // request codes; the fourth code is unused
    typedef enum logic [1:0] {
        REQ_NOTE     = 2'd0,
        REQ_SLOT_CNT = 2'd1,
        REQ_VAR_CNT  = 2'd2
    } req_type_t;

    typedef struct packed {
        req_type_t          req_type;
        logic [NOTE_W-1:0]  note;
        logic [VEL_W-1:0]   velocity;
        logic [SLOT_W-1:0]  slot;
        logic [CNT_W-1:0]   count;
    } req_t;

    typedef struct packed {
        logic               voiced;
        logic [NOTE_W-1:0]  out_note;
        logic [SLOT_W-1:0]  slot_index;
        logic [VAR_W-1:0]   variant_index;
        logic [GAIN_W-1:0]  gain;
    } result_t;

    // one entry of the per note and slot table
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] last;
    } var_entry_t;

endpackage

/* hdl/vlrr_mod.sv */
// ----------------------------------------------------------------------------
// vlrr_mod
// Iterative remainder of a 32-bit word by a small divisor, four bits a cycle.
// ----------------------------------------------------------------------------
module vlrr_mod (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [vlrr_pkg::RNG_W-1:0] dividend,
    input  logic [vlrr_pkg::CNT_W-1:0] divisor,
    output logic                       done,
    output logic [vlrr_pkg::VAR_W-1:0] remainder
);
    import vlrr_pkg::*;

    logic                  run_reg;
    logic                  done_reg;
    logic [MOD_STEP_W-1:0] step_reg;
    logic [RNG_W-1:0]      dvd_reg;
    logic [CNT_W-1:0]      dvs_reg;
    logic [VAR_W-1:0]      rem_reg;
    logic [VAR_W-1:0]      rem_next;

    // restoring steps over the next four dividend bits
    always_comb
    begin
        logic [CNT_W-1:0] trial;
        logic [VAR_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < MOD_BITS_PER_STEP; i++)
        begin
            trial = {r, dvd_reg[RNG_W-1-i]};
            if (trial >= dvs_reg)
                r = VAR_W'(trial - dvs_reg);
            else
                r = trial[VAR_W-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == MOD_STEP_W'(MOD_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[RNG_W-MOD_BITS_PER_STEP-1:0], {MOD_BITS_PER_STEP{1'b0}}};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* hdl/velocity_layer_round_robin_select.sv */
// ----------------------------------------------------------------------------
// velocity_layer_round_robin_select
// Velocity slot and round-robin variant selection for note events.
// ----------------------------------------------------------------------------
// After reset the block clears its tables with busy high; the seed port is
// live throughout. Table writes (slot count, variant count) are taken from
// idle and leave busy low. A note event holds busy until it ends in silence
// at the slot table, ends in silence at the variant table, finds a single
// variant in the slot, or finishes a draw, redrawing while the pick repeats
// the last variant; the busy time is set by the table read sequence and by
// the remainder unit, which loads, works through the dividend and then
// signals done on each draw. Each note event gives exactly one result beat,
// shown for one cycle with done high, in the same cycle that busy falls; the
// receiver cannot stall, so it must take every beat as it comes.
// ----------------------------------------------------------------------------
module velocity_layer_round_robin_select (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  vlrr_pkg::req_t             req,
    output logic                       done,
    output vlrr_pkg::result_t          result,
    input  logic                       cfg_we,
    input  logic [vlrr_pkg::RNG_W-1:0] cfg_wdata
);
    import vlrr_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT,
        S_QEST,
        S_CORR,
        S_VAR,
        S_LCG,
        S_MOD
    } state_t;

    state_t                state_reg;
    logic [TABLE_AW-1:0]   clr_cnt_reg;
    logic [RNG_W-1:0]      rng_reg;
    logic                  done_reg;
    result_t               result_reg;

    // item registers
    logic [NOTE_W-1:0]     note_reg;
    logic [VEL_W-1:0]      vel_reg;
    logic [CNT_W-1:0]      nslots_reg;
    logic [11:0]           num_reg;
    logic [SLOT_W-1:0]     qest_reg;
    logic [SLOT_W-1:0]     sidx_reg;
    logic [GAIN_W-1:0]     gain_reg;
    logic [CNT_W-1:0]      last_reg;

    // memories
    logic [CNT_W-1:0]      slot_mem [NUM_NOTES];
    var_entry_t            var_mem  [TABLE_DEPTH];
    logic [CNT_W-1:0]      slot_rd_reg;
    var_entry_t            var_rd_reg;

    logic                  accept;
    logic [CNT_W-1:0]      cnt_sat_slot;
    logic [CNT_W-1:0]      cnt_sat_var;
    logic [11:0]           num_next;
    logic [19:0]           qest_prod;
    logic [11:0]           q_back;
    logic [11:0]           q_rem;
    logic [CNT_W-1:0]      sidx_raw;
    logic [SLOT_W-1:0]     sidx_c;
    logic [TABLE_AW-1:0]   var_rd_addr;
    logic [RNG_W-1:0]      rng_next;
    logic                  mod_done;
    logic [VAR_W-1:0]      mod_rem;
    logic                  redraw;
    logic                  last_we;

    assign accept = start && (state_reg == S_IDLE);

    // saturate written counts
    assign cnt_sat_slot = (req.count > SLOT_CNT_MAX) ? SLOT_CNT_MAX : req.count;
    assign cnt_sat_var  = (req.count > VAR_CNT_MAX)  ? VAR_CNT_MAX  : req.count;

    // numerator of the rounded slot: 2v(n-1) + 127
    assign num_next = 12'({vel_reg, 1'b0} * 4'(slot_rd_reg - 1'b1)) + 12'd127;

    // quotient estimate num*129 >> 15, never above num/254, at most one low
    assign qest_prod = {num_reg, 7'b0} + 20'(num_reg);

    // correction step: remainder num - 254q, bump if still 254 or more
    assign q_back   = {qest_reg, 8'b0} - {7'b0, qest_reg, 1'b0};
    assign q_rem    = num_reg - q_back;
    assign sidx_raw = {1'b0, qest_reg} + ((q_rem >= 12'd254) ? 5'd1 : 5'd0);
    assign sidx_c   = (sidx_raw >= nslots_reg) ? SLOT_W'(nslots_reg - 1'b1)
                                               : sidx_raw[SLOT_W-1:0];

    assign var_rd_addr = (state_reg == S_CORR) ? {note_reg, sidx_c}
                                               : {note_reg, sidx_reg};

    // generator step
    assign rng_next = RNG_W'(rng_reg * LCG_MUL) + LCG_ADD;

    assign redraw  = ({1'b0, mod_rem} == last_reg);
    assign last_we = (state_reg == S_MOD) && mod_done && !redraw;

    vlrr_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == S_LCG),
        .dividend  (rng_next),
        .divisor   (var_rd_reg.cnt),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // slot count memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            slot_mem[clr_cnt_reg[NOTE_W-1:0]] <= '0;
        else if (accept && req.req_type == REQ_SLOT_CNT)
            slot_mem[req.note] <= cnt_sat_slot;
        slot_rd_reg <= slot_mem[req.note];
    end

    // variant count and last variant memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            var_mem[clr_cnt_reg].cnt  <= '0;
            var_mem[clr_cnt_reg].last <= LAST_NONE;
        end
        else if (accept && req.req_type == REQ_VAR_CNT)
            var_mem[{req.note, req.slot}].cnt <= cnt_sat_var;
        else if (last_we)
            var_mem[{note_reg, sidx_reg}].last <= {1'b0, mod_rem};
        var_rd_reg <= var_mem[var_rd_addr];
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                note_reg <= req.note;
                vel_reg  <= req.velocity;
            end
            S_SLOT:
            begin
                nslots_reg <= slot_rd_reg;
                num_reg    <= num_next;
                gain_reg   <= GAIN_W'(vel_reg * vel_reg);
            end
            S_QEST:
                qest_reg <= qest_prod[18:15];
            S_CORR:
                sidx_reg <= sidx_c;
            S_VAR:
                last_reg <= var_rd_reg.last;
            default:
            begin
            end
        endcase
    end

    // sequencer, generator state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            rng_reg     <= SEED_RESET;
            done_reg    <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_we)
                rng_reg <= cfg_wdata;
            else if (state_reg == S_LCG)
                rng_reg <= rng_next;

            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == TABLE_AW'(TABLE_DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (start && req.req_type == REQ_NOTE)
                        state_reg <= S_SLOT;
                end
                S_SLOT:
                begin
                    if (slot_rd_reg == '0)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{voiced: 1'b0, out_note: note_reg,
                                        slot_index: '0, variant_index: '0, gain: '0};
                        state_reg  <= S_IDLE;
                    end
                    else
                        state_reg <= S_QEST;
                end
                S_QEST:
                    state_reg <= S_CORR;
                S_CORR:
                    state_reg <= S_VAR;
                S_VAR:
                begin
                    if (var_rd_reg.cnt == '0)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{voiced: 1'b0, out_note: note_reg,
                                        slot_index: '0, variant_index: '0, gain: '0};
                        state_reg  <= S_IDLE;
                    end
                    else if (var_rd_reg.cnt == CNT_W'(1))
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{voiced: 1'b1, out_note: note_reg,
                                        slot_index: sidx_reg, variant_index: '0,
                                        gain: gain_reg};
                        state_reg  <= S_IDLE;
                    end
                    else
                        state_reg <= S_LCG;
                end
                S_LCG:
                    state_reg <= S_MOD;
                S_MOD:
                begin
                    if (mod_done)
                    begin
                        if (redraw)
                            state_reg <= S_LCG;
                        else
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '{voiced: 1'b1, out_note: note_reg,
                                            slot_index: sidx_reg, variant_index: mod_rem,
                                            gain: gain_reg};
                            state_reg  <= S_IDLE;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* test/vlrr_checker.sv */
// ----------------------------------------------------------------------------
// vlrr_checker
// Watches the request, result and seed ports of the round-robin selector.
// Keeps its own copy of the count tables, the last-played table and the
// generator. Works out the pick for every accepted note event and compares
// each result beat with the oldest pick still due.
// ----------------------------------------------------------------------------
module vlrr_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  vlrr_pkg::req_t             req,
    input  logic                       done,
    input  vlrr_pkg::result_t          result,
    input  logic                       cfg_we,
    input  logic [vlrr_pkg::RNG_W-1:0] cfg_wdata,
    output int                         fail_count,
    output int                         pending
);
    import vlrr_pkg::*;

    // shadow tables and generator
    logic [CNT_W-1:0] slot_counts    [NUM_NOTES];
    logic [CNT_W-1:0] variant_counts [TABLE_DEPTH];
    logic [CNT_W-1:0] last_played    [TABLE_DEPTH];
    logic [RNG_W-1:0] lcg_state;

    // picks waiting for their result beat, oldest first
    result_t picks_due [$];

    // written counts saturate at the table maximum
    function automatic logic [CNT_W-1:0] saturate(logic [CNT_W-1:0] c, logic [CNT_W-1:0] lim);
        return (c > lim) ? lim : c;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // slot by rounded velocity, then LCG draws avoiding the last variant played
    task automatic select_variant(input req_t r);
        result_t          pick;
        int               n;
        int               s;
        int               pos;
        logic [CNT_W-1:0] nvar;
        logic [CNT_W-1:0] chosen;
        logic [RNG_W-1:0] rem;
        pick          = '0;
        pick.out_note = r.note;
        n             = slot_counts[r.note];
        if (n != 0)
        begin
            s = (n <= 1) ? 0 : (2 * int'(r.velocity) * (n - 1) + 127) / 254;
            if (s >= n)
                s = n - 1;
            pos  = int'(r.note) * MAX_SLOTS + s;
            nvar = variant_counts[pos];
            if (nvar != 0)
            begin
                chosen = '0;
                // a single variant needs no draw and leaves the history alone
                if (nvar > 1)
                begin
                    do
                    begin
                        lcg_state = lcg_state * LCG_MUL + LCG_ADD;
                        rem       = lcg_state % RNG_W'(nvar);
                        chosen    = rem[CNT_W-1:0];
                    end
                    while (chosen == last_played[pos]);
                    last_played[pos] = chosen;
                end
                pick.voiced        = 1'b1;
                pick.slot_index    = s[SLOT_W-1:0];
                pick.variant_index = chosen[VAR_W-1:0];
                pick.gain          = GAIN_W'(int'(r.velocity) * int'(r.velocity));
            end
        end
        picks_due.push_back(pick);
    endtask

    task automatic apply_request(input req_t r);
        case (r.req_type)
            REQ_NOTE:
                select_variant(r);
            REQ_SLOT_CNT:
                slot_counts[r.note] = saturate(r.count, SLOT_CNT_MAX);
            REQ_VAR_CNT:
                variant_counts[int'(r.note) * MAX_SLOTS + int'(r.slot)] =
                    saturate(r.count, VAR_CNT_MAX);
            default:
                ; // unused code: no effect, no beat
        endcase
    endtask

    // sampled at the edge: all ports hold their pre-edge values here
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_NOTES; i++)
                slot_counts[i] = '0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                variant_counts[i] = '0;
                last_played[i]    = LAST_NONE;
            end
            lcg_state  = SEED_RESET;
            picks_due.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // result beat belongs to an earlier request, so check it first
            if (done)
            begin
                if (picks_due.size() == 0)
                begin
                    $error("result beat with no pick due (note %0d)", result.out_note);
                    fail_count++;
                end
                else
                begin
                    want = picks_due.pop_front();
                    check_field("voiced", want.voiced, result.voiced);
                    check_field("out_note", want.out_note, result.out_note);
                    check_field("slot_index", want.slot_index, result.slot_index);
                    check_field("variant_index", want.variant_index, result.variant_index);
                    check_field("gain", want.gain, result.gain);
                end
            end
            // seed write reloads the generator
            if (cfg_we)
                lcg_state = cfg_wdata;
            if (start && !busy)
                apply_request(req);
            pending = picks_due.size();
        end
    end

endmodule

/* test/tb_velocity_layer_round_robin_select.sv */
// ----------------------------------------------------------------------------
// tb_velocity_layer_round_robin_select
// Drives table writes and note events into the round-robin selector with
// random gaps, reloads the seed between phases, and leaves all prediction
// and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_velocity_layer_round_robin_select;
    import vlrr_pkg::*;

    localparam req_type_t REQ_UNUSED   = req_type_t'(2'd3);
    localparam int        CYCLE_LIMIT  = 1000000;
    localparam int        PHASES       = 6;
    localparam int        MIX_BEATS    = 220;
    localparam int        FOCUS_NOTES  = 6;
    localparam int        SETTLE_CYCLES = 40;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    req_t             req;
    logic             done;
    result_t          result;
    logic             cfg_we;
    logic [RNG_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int cycles     = 0;
    int no_gap_run = 0;
    int focus [FOCUS_NOTES];

    velocity_layer_round_robin_select u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    vlrr_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic req_t make_req(req_type_t kind, int note, int vel, int slot, int cnt);
        req_t r;
        r.req_type = kind;
        r.note     = NOTE_W'(note);
        r.velocity = VEL_W'(vel);
        r.slot     = SLOT_W'(slot);
        r.count    = CNT_W'(cnt);
        return r;
    endfunction

    // mostly short gaps, a few long ones, now and then a run with none
    function automatic int pick_gap();
        int r;
        if (no_gap_run > 0)
        begin
            no_gap_run--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            no_gap_run = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // hold the beat until accepted; start stays high when no gap follows
    task automatic send_beat(input req_t r);
        int gap;
        req   <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait until every pick has come back and the block has gone quiet
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_seed(input logic [RNG_W-1:0] seed);
        settle();
        cfg_wdata <= seed;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // give each focus note a slot count and variant counts for its slots
    task automatic prime_focus();
        int n;
        int vc;
        for (int i = 0; i < FOCUS_NOTES; i++)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) : $urandom_range(1, 16);
            send_beat(make_req(REQ_SLOT_CNT, focus[i], $urandom_range(0, 127),
                               $urandom_range(0, 15), n));
            if (n > MAX_SLOTS)
                n = MAX_SLOTS;
            for (int s = 0; s < n; s++)
            begin
                vc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                 : $urandom_range(1, 16);
                send_beat(make_req(REQ_VAR_CNT, focus[i], $urandom_range(0, 127), s, vc));
            end
        end
    endtask

    // mostly note events on primed notes, with table rewrites and noise mixed in
    function automatic req_t random_beat();
        int        r;
        int        note;
        int        cnt;
        req_type_t kind;
        r    = $urandom_range(0, 99);
        note = ($urandom_range(0, 99) < 85) ? focus[$urandom_range(0, FOCUS_NOTES - 1)]
                                            : $urandom_range(0, 127);
        cnt  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
        if (r < 62)
            kind = REQ_NOTE;
        else if (r < 77)
            kind = REQ_SLOT_CNT;
        else if (r < 95)
            kind = REQ_VAR_CNT;
        else
            kind = REQ_UNUSED;
        return make_req(kind, note, $urandom_range(0, 127), $urandom_range(0, 15), cnt);
    endfunction

    initial
    begin
        req_t b;
        int   sent;
        start     <= 1'b0;
        req       <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        rst_n     <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n     <= 1'b1;

        // directed part, seed zero
        load_seed('0);
        // silence: note never recorded
        send_beat(make_req(REQ_NOTE, 0, 127, 0, 0));
        // single slot, then silence on an empty variant entry
        send_beat(make_req(REQ_SLOT_CNT, 0, 0, 0, 1));
        send_beat(make_req(REQ_NOTE, 0, 100, 0, 0));
        // single variant: no draw
        send_beat(make_req(REQ_VAR_CNT, 0, 0, 0, 1));
        send_beat(make_req(REQ_NOTE, 0, 0, 0, 0));
        send_beat(make_req(REQ_NOTE, 0, 127, 15, 31));
        // oversized counts saturate
        send_beat(make_req(REQ_SLOT_CNT, 127, 0, 0, 31));
        send_beat(make_req(REQ_VAR_CNT, 127, 0, 15, 20));
        send_beat(make_req(REQ_NOTE, 127, 127, 0, 0));
        send_beat(make_req(REQ_NOTE, 127, 127, 0, 0));
        send_beat(make_req(REQ_NOTE, 127, 0, 0, 0));
        // stale last variant after the count shrinks
        send_beat(make_req(REQ_VAR_CNT, 127, 0, 0, 16));
        send_beat(make_req(REQ_NOTE, 127, 0, 0, 0));
        send_beat(make_req(REQ_NOTE, 127, 0, 0, 0));
        send_beat(make_req(REQ_VAR_CNT, 127, 0, 0, 2));
        send_beat(make_req(REQ_NOTE, 127, 0, 0, 0));
        send_beat(make_req(REQ_NOTE, 127, 0, 0, 0));
        // unused request code
        send_beat(make_req(REQ_UNUSED, 127, 127, 15, 31));
        // slot rounding either side of a boundary
        send_beat(make_req(REQ_SLOT_CNT, 64, 0, 0, 16));
        send_beat(make_req(REQ_VAR_CNT, 64, 0, 8, 3));
        send_beat(make_req(REQ_VAR_CNT, 64, 0, 7, 0));
        send_beat(make_req(REQ_NOTE, 64, 64, 0, 0));
        send_beat(make_req(REQ_NOTE, 64, 63, 0, 0));
        send_beat(make_req(REQ_SLOT_CNT, 5, 0, 0, 2));
        send_beat(make_req(REQ_VAR_CNT, 5, 0, 1, 3));
        send_beat(make_req(REQ_NOTE, 5, 64, 0, 0));
        send_beat(make_req(REQ_NOTE, 5, 63, 0, 0));

        // random phases, each with its own seed and set of busy notes
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                load_seed('1);
            else if (p == 1)
                load_seed(SEED_RESET);
            else
                load_seed($urandom);
            for (int i = 0; i < FOCUS_NOTES; i++)
                focus[i] = $urandom_range(0, 127);
            prime_focus();
            sent = 0;
            while (sent < MIX_BEATS)
            begin
                b = random_beat();
                send_beat(b);
                if (b.req_type != REQ_UNUSED)
                    sent++;
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
